### sv/lsmpd_pkg.sv
// Shared types, sizes and codes for the LIFO stack with pop-many and dump.
`default_nettype none

package lsmpd_pkg;

    // Stack storage and field sizes.
    localparam int DEPTH      = 32;
    localparam int MAX_OUT    = 32;
    localparam int WORD_W     = 32;
    localparam int CAP_W      = 6;
    localparam int CAP_RESET  = 5;
    localparam int CNT_W      = 6;
    localparam int FILL_OUT_W = 6;
    localparam int FILL_W     = $clog2(DEPTH + 1);
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int LIM_W      = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam int REM_W      = $clog2(MAX_OUT + 1);

    // Queue sizes; both depths are powers of two so the pointers wrap on their own.
    localparam int CQ_DEPTH   = 2;
    localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

    // Configuration register map: one register, index taken from paddr[2].
    localparam int CFG_AW           = 3;
    localparam logic REG_CAPACITY   = 1'b0;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_POPN = 2'd2,
        CMD_DUMP = 2'd3
    } t_cmd_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One classified command as it waits between the front and the back.
    typedef struct packed {
        t_cmd_op                   op;
        logic signed [WORD_W-1:0]  value;
        logic [REM_W-1:0]          count;
    } t_cmd;

    // One result word.
    typedef struct packed {
        logic signed [WORD_W-1:0]  data;
        logic                      has_data;
        t_status                   status;
        logic [FILL_OUT_W-1:0]     fill_after;
        logic                      last;
    } t_result;

endpackage

`default_nettype wire

### sv/lsmpd_front.sv
// Front end: accepts command words, saturates the pop-many count and queues them.
`default_nettype none

module lsmpd_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire logic [1:0]                      i_cmd,
    input  wire logic signed [lsmpd_pkg::WORD_W-1:0] i_value,
    input  wire logic [lsmpd_pkg::CNT_W-1:0]     i_count,
    output logic                                 o_full,
    output logic                                 o_head_valid,
    output lsmpd_pkg::t_cmd                      o_head,
    input  wire logic                            i_head_pop
);

    lsmpd_pkg::t_cmd r_q [lsmpd_pkg::CQ_DEPTH];
    logic [lsmpd_pkg::CQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [lsmpd_pkg::CQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [lsmpd_pkg::CQ_CNT_W-1:0] r_cnt, n_cnt;
    lsmpd_pkg::t_cmd cls;
    logic            wr_en;
    logic            rd_en;

    // Classify the incoming word; only pop-many keeps a count, capped at the result limit.
    always_comb begin
        cls.op    = lsmpd_pkg::t_cmd_op'(i_cmd);
        cls.value = i_value;
        cls.count = '0;
        if (cls.op == lsmpd_pkg::CMD_POPN) begin
            if ({1'b0, i_count} > (lsmpd_pkg::CNT_W + 1)'(lsmpd_pkg::MAX_OUT)) begin
                cls.count = lsmpd_pkg::REM_W'(lsmpd_pkg::MAX_OUT);
            end else begin
                cls.count = lsmpd_pkg::REM_W'(i_count);
            end
        end
    end

    assign o_full       = (r_cnt == lsmpd_pkg::CQ_CNT_W'(lsmpd_pkg::CQ_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rd_ptr];
    assign wr_en        = i_push && !o_full;
    assign rd_en        = i_head_pop && o_head_valid;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = wr_en ? lsmpd_pkg::CQ_PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = rd_en ? lsmpd_pkg::CQ_PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = lsmpd_pkg::CQ_CNT_W'(r_cnt + 1'b1);
        end else if (rd_en && !wr_en) begin
            n_cnt = lsmpd_pkg::CQ_CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

`default_nettype wire

### sv/lsmpd_back.sv
// Back end: owns the stack memory and fill level and turns commands into result words.
`default_nettype none

module lsmpd_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lsmpd_pkg::CAP_W-1:0]   i_capacity,
    input  wire logic                          i_head_valid,
    input  wire lsmpd_pkg::t_cmd               i_head,
    output logic                               o_head_pop,
    input  wire logic [lsmpd_pkg::OQ_CNT_W-1:0] i_oq_cnt,
    output logic                               o_res_valid,
    output lsmpd_pkg::t_result                 o_res,
    output logic [lsmpd_pkg::FILL_W-1:0]       o_fill
);

    localparam int DW = (lsmpd_pkg::FILL_W > lsmpd_pkg::REM_W) ?
                        lsmpd_pkg::FILL_W : lsmpd_pkg::REM_W;

    typedef enum logic {
        S_HEAD,
        S_LOOP
    } t_state;

    t_state                            r_state, n_state;
    logic [lsmpd_pkg::FILL_W-1:0]      r_fill, n_fill;
    logic [lsmpd_pkg::REM_W-1:0]       r_rem, n_rem;
    logic [lsmpd_pkg::ADDR_W-1:0]      r_idx, n_idx;
    logic                              r_b_valid, n_b_valid;
    logic                              r_b_has, n_b_has;
    lsmpd_pkg::t_status                r_b_status, n_b_status;
    logic [lsmpd_pkg::FILL_W-1:0]      r_b_fill, n_b_fill;
    logic                              r_b_last, n_b_last;

    logic signed [lsmpd_pkg::WORD_W-1:0] r_mem [lsmpd_pkg::DEPTH];
    logic signed [lsmpd_pkg::WORD_W-1:0] r_rd_data;

    logic [lsmpd_pkg::LIM_W-1:0]       cap_ext, depth_ext, limit, fill_ext;
    logic [DW-1:0]                     fill_dw;
    logic [lsmpd_pkg::REM_W-1:0]       dump_rem, cur_rem;
    logic [lsmpd_pkg::ADDR_W-1:0]      top_addr, cur_idx, rd_addr, wr_addr;
    logic                              room, go, wr_en, fill_zero;

    // Effective limit: capacity saturated to the physical depth.
    assign cap_ext   = lsmpd_pkg::LIM_W'(i_capacity);
    assign depth_ext = lsmpd_pkg::LIM_W'(lsmpd_pkg::DEPTH);
    assign limit     = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign fill_ext  = lsmpd_pkg::LIM_W'(r_fill);
    assign fill_zero = (r_fill == '0);

    // A dump lists at most MAX_OUT words.
    assign fill_dw  = DW'(r_fill);
    assign dump_rem = (fill_dw > DW'(lsmpd_pkg::MAX_OUT)) ?
                      lsmpd_pkg::REM_W'(lsmpd_pkg::MAX_OUT) :
                      lsmpd_pkg::REM_W'(r_fill);

    assign top_addr = lsmpd_pkg::ADDR_W'(r_fill - 1'b1);
    assign wr_addr  = lsmpd_pkg::ADDR_W'(r_fill);
    assign cur_idx  = (r_state == S_LOOP) ? r_idx : top_addr;
    assign cur_rem  = (r_state == S_LOOP) ? r_rem :
                      ((i_head.op == lsmpd_pkg::CMD_DUMP) ? dump_rem : i_head.count);

    // Issue only when the output queue can take the word in flight plus this one.
    assign room = ({1'b0, i_oq_cnt} + {{lsmpd_pkg::OQ_CNT_W{1'b0}}, r_b_valid})
                  < (lsmpd_pkg::OQ_CNT_W + 1)'(lsmpd_pkg::OQ_DEPTH);
    assign go   = i_head_valid && room;

    // One result step per cycle for the head command, while the output queue has room.
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_rem      = r_rem;
        n_idx      = r_idx;
        n_b_valid  = 1'b0;
        n_b_has    = 1'b0;
        n_b_status = lsmpd_pkg::ST_OK;
        n_b_fill   = r_fill;
        n_b_last   = 1'b1;
        o_head_pop = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = top_addr;
        if (go) begin
            unique case (i_head.op)
                lsmpd_pkg::CMD_PUSH: begin
                    n_b_valid  = 1'b1;
                    o_head_pop = 1'b1;
                    if (fill_ext >= limit) begin
                        n_b_status = lsmpd_pkg::ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        n_fill   = lsmpd_pkg::FILL_W'(r_fill + 1'b1);
                        n_b_fill = n_fill;
                    end
                end
                lsmpd_pkg::CMD_POP: begin
                    n_b_valid  = 1'b1;
                    o_head_pop = 1'b1;
                    if (fill_zero) begin
                        n_b_status = lsmpd_pkg::ST_EMPTY;
                    end else begin
                        n_b_has  = 1'b1;
                        n_fill   = lsmpd_pkg::FILL_W'(r_fill - 1'b1);
                        n_b_fill = n_fill;
                    end
                end
                lsmpd_pkg::CMD_POPN: begin
                    if (cur_rem == '0) begin
                        // Zero count gives no result at all.
                        o_head_pop = 1'b1;
                        n_state    = S_HEAD;
                    end else if (fill_zero) begin
                        // Ran out: closing empty word.
                        n_b_valid  = 1'b1;
                        n_b_status = lsmpd_pkg::ST_EMPTY;
                        o_head_pop = 1'b1;
                        n_state    = S_HEAD;
                    end else begin
                        n_b_valid = 1'b1;
                        n_b_has   = 1'b1;
                        n_fill    = lsmpd_pkg::FILL_W'(r_fill - 1'b1);
                        n_b_fill  = n_fill;
                        n_b_last  = (cur_rem == lsmpd_pkg::REM_W'(1));
                        n_rem     = lsmpd_pkg::REM_W'(cur_rem - 1'b1);
                        if (n_b_last) begin
                            o_head_pop = 1'b1;
                            n_state    = S_HEAD;
                        end else begin
                            n_state    = S_LOOP;
                        end
                    end
                end
                lsmpd_pkg::CMD_DUMP: begin
                    n_b_valid = 1'b1;
                    if (fill_zero) begin
                        n_b_status = lsmpd_pkg::ST_EMPTY;
                        o_head_pop = 1'b1;
                        n_state    = S_HEAD;
                    end else begin
                        rd_addr  = cur_idx;
                        n_b_has  = 1'b1;
                        n_b_last = (cur_rem == lsmpd_pkg::REM_W'(1));
                        n_rem    = lsmpd_pkg::REM_W'(cur_rem - 1'b1);
                        n_idx    = lsmpd_pkg::ADDR_W'(cur_idx - 1'b1);
                        if (n_b_last) begin
                            o_head_pop = 1'b1;
                            n_state    = S_HEAD;
                        end else begin
                            n_state    = S_LOOP;
                        end
                    end
                end
            endcase
        end
    end

    // Sequencer state, fill level and the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_HEAD;
            r_fill    <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_b_valid <= n_b_valid;
        end
        r_rem      <= n_rem;
        r_idx      <= n_idx;
        r_b_has    <= n_b_has;
        r_b_status <= n_b_status;
        r_b_fill   <= n_b_fill;
        r_b_last   <= n_b_last;
    end

    // Stack memory with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_head.value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Join the read data with the result stage.
    always_comb begin
        o_res.data       = r_b_has ? r_rd_data : '0;
        o_res.has_data   = r_b_has;
        o_res.status     = r_b_status;
        o_res.fill_after = lsmpd_pkg::FILL_OUT_W'(r_b_fill);
        o_res.last       = r_b_last;
    end

    assign o_res_valid = r_b_valid;
    assign o_fill      = r_fill;

endmodule

`default_nettype wire

### sv/lsmpd_outq.sv
// Output queue that holds result words until the consumer pops them.
`default_nettype none

module lsmpd_outq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_wr,
    input  wire lsmpd_pkg::t_result           i_wdata,
    input  wire logic                         i_rd,
    output logic                              o_empty,
    output lsmpd_pkg::t_result                o_rdata,
    output logic [lsmpd_pkg::OQ_CNT_W-1:0]    o_cnt
);

    lsmpd_pkg::t_result r_q [lsmpd_pkg::OQ_DEPTH];
    logic [lsmpd_pkg::OQ_PTR_W-1:0] r_wr_ptr;
    logic [lsmpd_pkg::OQ_PTR_W-1:0] r_rd_ptr;
    logic [lsmpd_pkg::OQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                           rd_en;

    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_q[r_rd_ptr];
    assign o_cnt   = r_cnt;
    assign rd_en   = i_rd && !o_empty;

    // Occupancy follows writes and reads; the back end never writes when full.
    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !rd_en) begin
            n_cnt = lsmpd_pkg::OQ_CNT_W'(r_cnt + 1'b1);
        end else if (rd_en && !i_wr) begin
            n_cnt = lsmpd_pkg::OQ_CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= lsmpd_pkg::OQ_PTR_W'(r_wr_ptr + 1'b1);
            end
            if (rd_en) begin
                r_rd_ptr <= lsmpd_pkg::OQ_PTR_W'(r_rd_ptr + 1'b1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

### sv/lifo_stack_multi_pop_dump_core.sv
// Top level: configuration register, front end, back end and output queue.
// An accepted word's results pass the result stage register and the output queue to reach the
// ports. Push and pop give one result word each; pop-many and dump give one result per cycle
// while the output queue has room, set by the single read port of the stack memory, and hold
// the command queue meanwhile. Reset clears the fill level, both queues and sets capacity to
// 5; memory contents are not cleared, since only entries below the fill level are ever read.
`default_nettype none

module lifo_stack_multi_pop_dump_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Command queue side.
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [1:0]                          i_cmd,
    input  wire logic signed [lsmpd_pkg::WORD_W-1:0] i_value,
    input  wire logic [lsmpd_pkg::CNT_W-1:0]         i_count,
    // Result queue side.
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [lsmpd_pkg::WORD_W-1:0]      o_data,
    output logic                                     o_has_data,
    output logic [1:0]                               o_status,
    output logic [lsmpd_pkg::FILL_OUT_W-1:0]         o_fill_after,
    output logic                                     o_last,
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lsmpd_pkg::CFG_AW-1:0]        paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    logic [lsmpd_pkg::CAP_W-1:0]     r_capacity;
    logic                            cfg_wr;
    logic                            head_valid;
    lsmpd_pkg::t_cmd                 head;
    logic                            head_pop;
    logic [lsmpd_pkg::OQ_CNT_W-1:0]  oq_cnt;
    logic                            res_valid;
    lsmpd_pkg::t_result              res;
    lsmpd_pkg::t_result              oq_head;
    logic [lsmpd_pkg::FILL_W-1:0]    fill;

    // Capacity register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lsmpd_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lsmpd_pkg::CAP_W'(lsmpd_pkg::CAP_RESET);
        end else if (cfg_wr) begin
            r_capacity <= pwdata[lsmpd_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == lsmpd_pkg::REG_CAPACITY) ? 32'(r_capacity) : '0;

    lsmpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_count      (i_count),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_head_pop   (head_pop)
    );

    lsmpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_capacity   (r_capacity),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .i_oq_cnt     (oq_cnt),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_fill       (fill)
    );

    lsmpd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (res),
        .i_rd    (pop),
        .o_empty (empty),
        .o_rdata (oq_head),
        .o_cnt   (oq_cnt)
    );

    assign o_data       = oq_head.data;
    assign o_has_data   = oq_head.has_data;
    assign o_status     = oq_head.status;
    assign o_fill_after = oq_head.fill_after;
    assign o_last       = oq_head.last;

    // The fill level never passes the physical depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= lsmpd_pkg::FILL_W'(lsmpd_pkg::DEPTH))
        else $error("stack fill level above depth");

    // The issue credit keeps the output queue from overflowing.
    a_oq_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (oq_cnt < lsmpd_pkg::OQ_CNT_W'(lsmpd_pkg::OQ_DEPTH)))
        else $error("result word written into a full output queue");

    // The back end retires only a command that is present.
    a_head_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_pop |-> head_valid)
        else $error("command retired from an empty queue");

endmodule

`default_nettype wire

### sim/lifo_stack_multi_pop_dump_core_tb.sv
// Self-checking testbench for the bounded LIFO stack with pop-many and dump.
`default_nettype none

module lifo_stack_multi_pop_dump_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted word or register access before the run is abandoned.
    localparam int STALL_LIMIT = 1000;
    // Cycles to let the block finish commands that produce no result words.
    localparam int SETTLE_CYCLES = 10;
    localparam logic [lsmpd_pkg::CFG_AW-1:0] CAP_ADDR = {lsmpd_pkg::REG_CAPACITY, 2'b00};

    // One stimulus row; typed rows carry their expected word, silent rows expect none.
    typedef struct packed {
        lsmpd_pkg::t_cmd_op  op;
        logic [31:0]         val;
        logic [5:0]          cnt;
        logic                typed;
        logic                silent;
        lsmpd_pkg::t_result  want;
    } t_stim_row;

    localparam lsmpd_pkg::t_result EMPTY_WORD =
        '{32'sd0, 1'b0, lsmpd_pkg::ST_EMPTY, 6'd0, 1'b1};
    localparam lsmpd_pkg::t_result NO_CHECK   = '0;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               push = 1'b0;
    logic                               full;
    logic [1:0]                         i_cmd = '0;
    logic signed [31:0]                 i_value = '0;
    logic [lsmpd_pkg::CNT_W-1:0]        i_count = '0;
    logic                               empty;
    logic                               pop = 1'b0;
    logic signed [31:0]                 o_data;
    logic                               o_has_data;
    logic [1:0]                         o_status;
    logic [lsmpd_pkg::FILL_OUT_W-1:0]   o_fill_after;
    logic                               o_last;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [lsmpd_pkg::CFG_AW-1:0]       paddr = '0;
    logic [31:0]                        pwdata = '0;
    logic [31:0]                        prdata;
    logic                               pready;

    lifo_stack_multi_pop_dump_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_count      (i_count),
        .empty        (empty),
        .pop          (pop),
        .o_data       (o_data),
        .o_has_data   (o_has_data),
        .o_status     (o_status),
        .o_fill_after (o_fill_after),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Directed part: empty-stack cases first, then fill to the reset capacity and unwind.
    t_stim_row directed_rows [18] = '{
        '{lsmpd_pkg::CMD_POP,  32'h0000_0000, 6'd0,  1'b1, 1'b0, EMPTY_WORD},
        '{lsmpd_pkg::CMD_DUMP, 32'h1234_5678, 6'd63, 1'b1, 1'b0, EMPTY_WORD},
        '{lsmpd_pkg::CMD_POPN, 32'h0000_0000, 6'd0,  1'b1, 1'b1, NO_CHECK},
        '{lsmpd_pkg::CMD_POPN, 32'h0000_0000, 6'd5,  1'b1, 1'b0, EMPTY_WORD},
        '{lsmpd_pkg::CMD_PUSH, 32'h7FFF_FFFF, 6'd0,  1'b1, 1'b0,
          '{32'sd0, 1'b0, lsmpd_pkg::ST_OK, 6'd1, 1'b1}},
        '{lsmpd_pkg::CMD_PUSH, 32'h8000_0000, 6'd0,  1'b1, 1'b0,
          '{32'sd0, 1'b0, lsmpd_pkg::ST_OK, 6'd2, 1'b1}},
        '{lsmpd_pkg::CMD_PUSH, 32'h0000_0000, 6'd0,  1'b1, 1'b0,
          '{32'sd0, 1'b0, lsmpd_pkg::ST_OK, 6'd3, 1'b1}},
        '{lsmpd_pkg::CMD_PUSH, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b0,
          '{32'sd0, 1'b0, lsmpd_pkg::ST_OK, 6'd4, 1'b1}},
        '{lsmpd_pkg::CMD_PUSH, 32'h5555_5555, 6'd0,  1'b1, 1'b0,
          '{32'sd0, 1'b0, lsmpd_pkg::ST_OK, 6'd5, 1'b1}},
        '{lsmpd_pkg::CMD_PUSH, 32'hAAAA_AAAA, 6'd0,  1'b1, 1'b0,
          '{32'sd0, 1'b0, lsmpd_pkg::ST_FULL, 6'd5, 1'b1}},
        '{lsmpd_pkg::CMD_DUMP, 32'h0000_0000, 6'd0,  1'b0, 1'b0, NO_CHECK},
        '{lsmpd_pkg::CMD_POP,  32'h0000_0000, 6'd0,  1'b0, 1'b0, NO_CHECK},
        '{lsmpd_pkg::CMD_POPN, 32'h0000_0000, 6'd2,  1'b0, 1'b0, NO_CHECK},
        '{lsmpd_pkg::CMD_POPN, 32'h0000_0000, 6'd63, 1'b0, 1'b0, NO_CHECK},
        '{lsmpd_pkg::CMD_PUSH, 32'h0000_0001, 6'd0,  1'b1, 1'b0,
          '{32'sd0, 1'b0, lsmpd_pkg::ST_OK, 6'd1, 1'b1}},
        '{lsmpd_pkg::CMD_PUSH, 32'h0000_0002, 6'd63, 1'b0, 1'b0, NO_CHECK},
        '{lsmpd_pkg::CMD_DUMP, 32'h0000_0000, 6'd0,  1'b0, 1'b0, NO_CHECK},
        '{lsmpd_pkg::CMD_POP,  32'h0000_0000, 6'd0,  1'b0, 1'b0, NO_CHECK}
    };

    // Mirror of the stack contents and the capacity setting.
    logic signed [31:0] stack_words [lsmpd_pkg::DEPTH];
    int                 held;
    int                 cap_setting;
    lsmpd_pkg::t_result step_out [$];
    lsmpd_pkg::t_result awaited_results [$];

    // Flags and counters for the command, result and watchdog processes; some are shared between them.
    bit gaps_on = 1'b1;
    int park_cycles = 0;
    int n_bad = 0;
    int n_results = 0;
    int n_cmds = 0;
    int n_pushes = 0;
    int n_popns = 0;
    int n_dumps = 0;
    int n_cfg = 0;
    int idle_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one command to the mirror and leave the result words it causes in step_out.
    function automatic void apply_stack_cmd(input lsmpd_pkg::t_cmd_op op,
                                            input logic [31:0] word,
                                            input logic [5:0] cnt);
        int                 lim;
        int                 reps;
        lsmpd_pkg::t_result r;
        step_out.delete();
        lim = (cap_setting > lsmpd_pkg::DEPTH) ? lsmpd_pkg::DEPTH : cap_setting;
        r = '0;
        case (op)
            lsmpd_pkg::CMD_PUSH: begin
                if (held >= lim) begin
                    r.status = lsmpd_pkg::ST_FULL;
                end else begin
                    stack_words[held] = word;
                    held++;
                    r.status = lsmpd_pkg::ST_OK;
                end
                r.fill_after = 6'(held);
                step_out.push_back(r);
            end
            lsmpd_pkg::CMD_POP, lsmpd_pkg::CMD_POPN: begin
                // A single pop behaves as pop-many with a count of one.
                if (op == lsmpd_pkg::CMD_POP) reps = 1;
                else reps = (cnt > lsmpd_pkg::MAX_OUT) ? lsmpd_pkg::MAX_OUT : int'(cnt);
                for (int k = 0; k < reps; k++) begin
                    if (held == 0) begin
                        step_out.push_back(EMPTY_WORD);
                        break;
                    end
                    held--;
                    r.data = stack_words[held];
                    r.has_data = 1'b1;
                    r.status = lsmpd_pkg::ST_OK;
                    r.fill_after = 6'(held);
                    step_out.push_back(r);
                end
            end
            default: begin
                // Dump walks from the top down and leaves the stack as it is.
                if (held == 0) begin
                    step_out.push_back(EMPTY_WORD);
                end else begin
                    for (int k = held - 1; k >= 0 && (held - 1 - k) < lsmpd_pkg::MAX_OUT;
                         k--) begin
                        r.data = stack_words[k];
                        r.has_data = 1'b1;
                        r.status = lsmpd_pkg::ST_OK;
                        r.fill_after = 6'(held);
                        step_out.push_back(r);
                    end
                end
            end
        endcase
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end else begin
            r = '0;
        end
    endfunction

    function automatic t_stim_row plain(input lsmpd_pkg::t_cmd_op op, input logic [31:0] val,
                                        input logic [5:0] cnt);
        t_stim_row row;
        row = '0;
        row.op = op;
        row.val = val;
        row.cnt = cnt;
        return row;
    endfunction

    // Words lean toward the signed extremes and the all-zero and all-one patterns.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [5:0] pick_count();
        if ($urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, 6));
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            n_bad++;
        end
    endfunction

    // Offer one command word after a random gap and record what it should produce.
    task automatic offer(input t_stim_row row);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= row.op;
        i_value <= row.val;
        i_count <= row.cnt;
        do @(posedge i_clk); while (full);
        apply_stack_cmd(row.op, row.val, row.cnt);
        if (!row.typed) begin
            foreach (step_out[k]) awaited_results.push_back(step_out[k]);
        end else if (!row.silent) begin
            awaited_results.push_back(row.want);
        end
        n_cmds++;
        if (row.op == lsmpd_pkg::CMD_PUSH) n_pushes++;
        if (row.op == lsmpd_pkg::CMD_POPN) n_popns++;
        if (row.op == lsmpd_pkg::CMD_DUMP) n_dumps++;
    endtask

    task automatic run_mix(input int n, input int push_pct);
        lsmpd_pkg::t_cmd_op op;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < push_pct) begin
                op = lsmpd_pkg::CMD_PUSH;
            end else begin
                case ($urandom_range(0, 2))
                    0: op = lsmpd_pkg::CMD_POP;
                    1: op = lsmpd_pkg::CMD_POPN;
                    default: op = lsmpd_pkg::CMD_DUMP;
                endcase
            end
            offer(plain(op, pick_word(), pick_count()));
        end
    endtask

    // Wait until every expected word is out, then let silent commands finish.
    task automatic settle();
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic apb_xfer(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= CAP_ADDR;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Change the capacity while the block is idle and read it back.
    task automatic set_capacity(input int cap);
        logic [31:0] rd;
        push <= 1'b0;
        settle();
        apb_xfer(1'b1, 32'(cap), rd);
        cap_setting = cap;
        apb_xfer(1'b0, '0, rd);
        check_field("capacity", 32'(cap), rd);
        n_cfg++;
    endtask

    // Command side and phase sequencing.
    initial begin : command_source
        logic [31:0] rd;
        held = 0;
        cap_setting = lsmpd_pkg::CAP_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_xfer(1'b0, '0, rd);
        check_field("capacity", 32'(lsmpd_pkg::CAP_RESET), rd);

        foreach (directed_rows[k]) offer(directed_rows[k]);

        // Zero capacity refuses every push; one word from the directed part is still held.
        set_capacity(0);
        run_mix(8, 50);

        // Oversized capacity saturates at the full depth; the receiver parks meanwhile.
        set_capacity(63);
        park_cycles = 150;
        repeat (lsmpd_pkg::DEPTH + 2) offer(plain(lsmpd_pkg::CMD_PUSH, pick_word(), 6'd0));
        offer(plain(lsmpd_pkg::CMD_DUMP, pick_word(), pick_count()));
        offer(plain(lsmpd_pkg::CMD_POPN, pick_word(), 6'd63));
        run_mix(12, 50);

        set_capacity(1);
        gaps_on = 1'b0;
        run_mix(15, 50);

        set_capacity(20);
        gaps_on = 1'b1;
        run_mix(30, 70);

        // Limit may lie below the fill level: held words stay, pushes are refused while it does.
        set_capacity(3);
        run_mix(20, 40);

        set_capacity(lsmpd_pkg::DEPTH);
        gaps_on = 1'b0;
        run_mix(20, 60);

        set_capacity($urandom_range(1, lsmpd_pkg::DEPTH));
        gaps_on = 1'b1;
        run_mix(15, 50);

        push <= 1'b0;
        settle();
        $display("Ran %0d commands (%0d pushes, %0d pop-many, %0d dumps), %0d result words.",
                 n_cmds, n_pushes, n_popns, n_dumps, n_results);
        $display("Capacity set %0d times, covering zero, saturation and a limit below fill.",
                 n_cfg);
        if (n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side: random stalls, one long park, and a field-by-field compare.
    initial begin : result_sink
        lsmpd_pkg::t_result want;
        int                 stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (park_cycles > 0) begin
                pop <= 1'b0;
                repeat (park_cycles) @(posedge i_clk);
                park_cycles = 0;
            end else begin
                stall = gaps_on ? $urandom_range(0, 4) : 0;
                if (stall > 0) begin
                    pop <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            n_results++;
            if (awaited_results.size() == 0) begin
                $error("result word with nothing expected: data %0h", o_data);
                n_bad++;
            end else begin
                want = awaited_results.pop_front();
                check_field("data", want.data, o_data);
                check_field("has_data", 32'(want.has_data), 32'(o_has_data));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("fill_after", 32'(want.fill_after), 32'(o_fill_after));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // Watchdog on cycles in which no word and no register access moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || psel) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Timed out with %0d result words still expected.",
                         awaited_results.size());
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

`default_nettype wire
